// ===== design/mps_scan_pkg.sv =====
// Package with keyword tables, code constants and widths for the MPS section record scanner.
`default_nettype none

package mps_scan_pkg;

  localparam int OFFSET_WIDTH_DEF = 32;
  localparam int LINE_OFS_W       = 32;

  localparam int KW_COUNT    = 12;
  localparam int KW_SECTIONS = 9;

  // Result classes.
  localparam logic [1:0] CLS_SECTION = 2'd0;
  localparam logic [1:0] CLS_HEADER  = 2'd1;
  localparam logic [1:0] CLS_INVALID = 2'd2;

  // Section kinds.
  localparam logic [3:0] KIND_ROWS     = 4'd0;
  localparam logic [3:0] KIND_COLUMNS  = 4'd1;
  localparam logic [3:0] KIND_RHS      = 4'd2;
  localparam logic [3:0] KIND_BOUNDS   = 4'd3;
  localparam logic [3:0] KIND_RANGES   = 4'd4;
  localparam logic [3:0] KIND_QUADOBJ  = 4'd5;
  localparam logic [3:0] KIND_QMATRIX  = 4'd6;
  localparam logic [3:0] KIND_QCMATRIX = 4'd7;
  localparam logic [3:0] KIND_ENDATA   = 4'd8;

  // Matched keyword codes: none, section kind plus one, or header base plus offset.
  localparam logic [3:0] MK_NONE     = 4'd0;
  localparam logic [3:0] MK_SEC_LAST = 4'd9;
  localparam logic [3:0] MK_HDR_BASE = 4'd10;
  localparam logic [3:0] MK_LAST     = 4'd12;

  localparam logic [3:0] COL_MAX = 4'd15;

  // Special bytes.
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_DOLL  = 8'h24;

  // Keyword text, left aligned: character i sits in bits [63-8i -: 8].
  localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
    {"ROWS", 32'h0},
    {"COLUMNS", 8'h0},
    {"RHS", 40'h0},
    {"BOUNDS", 16'h0},
    {"RANGES", 16'h0},
    {"QUADOBJ", 8'h0},
    {"QMATRIX", 8'h0},
    "QCMATRIX",
    {"ENDATA", 16'h0},
    {"NAME", 32'h0},
    "OBJSENSE",
    {"OBJNAME", 8'h0}
  };

  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd4, 4'd7, 4'd3, 4'd6, 4'd6, 4'd7, 4'd7, 4'd8, 4'd6, 4'd4, 4'd8, 4'd7
  };

  function automatic logic [7:0] kw_char(input int k, input logic [2:0] idx);
    logic [63:0] txt;
    txt = KW_TEXT[k];
    return txt[63 - 8 * int'(idx) -: 8];
  endfunction

endpackage

`default_nettype wire

// ===== design/mps_section_record_scanner_core.sv =====
// Top level of the MPS section record scanner: byte register, line classifier, result register.
`default_nettype none

// The scanner takes the text of an MPS file one byte per transfer and reports
// every candidate indicator line (first byte above 0x20 and not '*' or '$')
// when that line ends at a newline or at the byte flagged by end_of_data.
// Each report carries the class (section, header or invalid record), the
// section kind, the offset of the line's first byte (clipped to 32 bits) and
// whether this section kind is reported for the first time in the file.
// Throughput is one byte per clock: an accepted byte sits in an input
// register, a single pass of keyword compare logic updates the line state,
// and a result lands in the output register. The input side is stalled
// only when the output register holds a result that has not been taken and
// the registered byte would produce another one; bytes that close no line
// keep flowing. The transfer that carries end_of_data starts a new file:
// offsets restart at zero and no section counts as seen.
module mps_section_record_scanner_core
  import mps_scan_pkg::*;
#(
  parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output      logic                  in_stall,
  input  wire logic [7:0]            in_data_byte,
  input  wire logic                  in_end_of_data,
  output      logic                  out_valid,
  input  wire logic                  out_stall,
  output      logic [1:0]            out_match_class,
  output      logic [3:0]            out_section_kind,
  output      logic [LINE_OFS_W-1:0] out_line_offset,
  output      logic                  out_first_occurrence
);

  // Input register.
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_eod_r;

  // Scanner state.
  logic [OFFSET_WIDTH-1:0] byte_pos_r, byte_pos_nxt;
  logic                    after_nl_r, after_nl_nxt;
  logic                    line_mode_r, line_mode_nxt;
  logic [OFFSET_WIDTH-1:0] rec_start_r, rec_start_nxt;
  logic [3:0]              col_r, col_nxt;
  logic [KW_COUNT-1:0]     alive_r, alive_nxt;
  logic [3:0]              mk_r, mk_nxt;
  logic                    tail_r, tail_nxt;
  logic [KW_SECTIONS-1:0]  seen_r, seen_nxt;

  // Output register.
  logic                  out_valid_r;
  logic [1:0]            out_cls_r;
  logic [3:0]            out_kind_r;
  logic [LINE_OFS_W-1:0] out_ofs_r;
  logic                  out_first_r;

  // Classifier results.
  logic                  has_result;
  logic [1:0]            res_cls;
  logic [3:0]            res_kind;
  logic                  res_first;
  logic [LINE_OFS_W-1:0] rs_clip;
  logic                  advance;

  // Working values.
  logic                    start;
  logic                    lm_w;
  logic [OFFSET_WIDTH-1:0] rs_w;
  logic [3:0]              cc_w;
  logic [KW_COUNT-1:0]     alive_w;
  logic [3:0]              mk_w;
  logic                    tail_w;
  logic                    blank;
  logic                    header;
  logic                    sect_ok;
  logic [3:0]              sk;

  assign blank = (s1_byte_r == CH_SPACE) || (s1_byte_r == CH_TAB) || (s1_byte_r == CH_CR);
  assign start = !line_mode_r && after_nl_r && (s1_byte_r > CH_SPACE) &&
                 (s1_byte_r != CH_STAR) && (s1_byte_r != CH_DOLL);

  // Clip the record offset to the 32-bit result field.
  generate
    if (OFFSET_WIDTH > LINE_OFS_W) begin : g_clip
      assign rs_clip = (|rs_w[OFFSET_WIDTH-1:LINE_OFS_W]) ? '1 : rs_w[LINE_OFS_W-1:0];
    end else begin : g_ext
      assign rs_clip = LINE_OFS_W'(rs_w);
    end
  endgenerate

  always_comb begin
    // A candidate line opens with fresh match state.
    lm_w    = line_mode_r | start;
    rs_w    = start ? byte_pos_r : rec_start_r;
    cc_w    = start ? 4'd0 : col_r;
    alive_w = start ? '1 : alive_r;
    mk_w    = start ? MK_NONE : mk_r;
    tail_w  = start ? 1'b0 : tail_r;

    has_result = 1'b0;
    line_mode_nxt = lm_w;
    col_nxt = cc_w;

    // Consume the byte unless it is the newline that closes the line.
    if (lm_w && (s1_byte_r != CH_LF)) begin
      if ((mk_w != MK_NONE) && (mk_w <= MK_SEC_LAST) && !blank) begin
        tail_w = 1'b1;
      end
      for (int k = 0; k < KW_COUNT; k++) begin
        if (alive_w[k]) begin
          if (cc_w < KW_LEN[k]) begin
            if (s1_byte_r != kw_char(k, cc_w[2:0])) begin
              alive_w[k] = 1'b0;
            end else if ((cc_w == KW_LEN[k] - 4'd1) && (k < KW_SECTIONS)) begin
              mk_w       = 4'(k + 1);
              tail_w     = 1'b0;
              alive_w[k] = 1'b0;
            end
          end else begin
            if ((cc_w == KW_LEN[k]) && (s1_byte_r <= CH_SPACE) && (k >= KW_SECTIONS)) begin
              mk_w = MK_HDR_BASE + 4'(k - KW_SECTIONS);
            end
            alive_w[k] = 1'b0;
          end
        end
      end
      col_nxt = (cc_w < COL_MAX) ? cc_w + 4'd1 : COL_MAX;
    end

    // Line classification.
    header = (mk_w >= MK_HDR_BASE);
    for (int k = KW_SECTIONS; k < KW_COUNT; k++) begin
      if (alive_w[k] && (col_nxt == KW_LEN[k])) begin
        header = 1'b1;
      end
    end
    sk = mk_w - 4'd1;
    sect_ok = 1'b0;
    if ((mk_w != MK_NONE) && (mk_w <= MK_SEC_LAST)) begin
      sect_ok = (sk == KIND_QCMATRIX) ? tail_w : !tail_w;
    end

    res_cls   = CLS_INVALID;
    res_kind  = KIND_ROWS;
    res_first = 1'b0;
    seen_nxt  = seen_r;
    if (lm_w && ((s1_byte_r == CH_LF) || s1_eod_r)) begin
      has_result    = 1'b1;
      line_mode_nxt = 1'b0;
      if (header) begin
        res_cls = CLS_HEADER;
      end else if (sect_ok) begin
        res_cls   = CLS_SECTION;
        res_kind  = sk;
        res_first = !seen_r[sk];
        seen_nxt[sk] = 1'b1;
      end
    end

    rec_start_nxt = rs_w;
    alive_nxt     = alive_w;
    mk_nxt        = mk_w;
    tail_nxt      = tail_w;
    after_nl_nxt  = (s1_byte_r == CH_LF);
    byte_pos_nxt  = (&byte_pos_r) ? byte_pos_r : byte_pos_r + 1'b1;

    // End of data closes the file and restores the reset state.
    if (s1_eod_r) begin
      byte_pos_nxt  = '0;
      after_nl_nxt  = 1'b1;
      line_mode_nxt = 1'b0;
      rec_start_nxt = '0;
      col_nxt       = 4'd0;
      alive_nxt     = '0;
      mk_nxt        = MK_NONE;
      tail_nxt      = 1'b0;
      seen_nxt      = '0;
    end
  end

  assign advance  = s1_valid_r && (!has_result || !out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte_r <= in_data_byte;
      s1_eod_r  <= in_end_of_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_pos_r  <= '0;
      after_nl_r  <= 1'b1;
      line_mode_r <= 1'b0;
      rec_start_r <= '0;
      col_r       <= 4'd0;
      alive_r     <= '0;
      mk_r        <= MK_NONE;
      tail_r      <= 1'b0;
      seen_r      <= '0;
    end else if (advance) begin
      byte_pos_r  <= byte_pos_nxt;
      after_nl_r  <= after_nl_nxt;
      line_mode_r <= line_mode_nxt;
      rec_start_r <= rec_start_nxt;
      col_r       <= col_nxt;
      alive_r     <= alive_nxt;
      mk_r        <= mk_nxt;
      tail_r      <= tail_nxt;
      seen_r      <= seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && has_result) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && has_result) begin
      out_cls_r   <= res_cls;
      out_kind_r  <= res_kind;
      out_ofs_r   <= rs_clip;
      out_first_r <= res_first;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_match_class      = out_cls_r;
  assign out_section_kind     = out_kind_r;
  assign out_line_offset      = out_ofs_r;
  assign out_first_occurrence = out_first_r;

  // Headers and invalid records carry a zero kind and no first-hit flag.
  a_non_section_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_cls_r != CLS_SECTION) |-> (out_kind_r == KIND_ROWS) && !out_first_r)
    else $error("non-section result with kind or first flag set");

  // The end-of-data byte restarts offsets and forgets seen sections.
  a_eod_restart: assert property (@(posedge clk) disable iff (!rst_n)
    advance && s1_eod_r |=> (byte_pos_r == '0) && (seen_r == '0) && !line_mode_r)
    else $error("state not restored after end of data");

  // The matched keyword code stays within the defined codes.
  a_mk_range: assert property (@(posedge clk) disable iff (!rst_n)
    mk_r <= MK_LAST)
    else $error("matched keyword code out of range");

  // A result never overwrites one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |-> !(advance && has_result))
    else $error("pending result overwritten");

endmodule

`default_nettype wire
